// ===== rtl/imra_pkg.sv =====
// ----------------------------------------------------------------------------
// imra_pkg
// Shared types and constants of the I2C master register access block.
// ----------------------------------------------------------------------------
package imra_pkg;

   // write buffer sizing
   localparam int WRITE_DEPTH = 16;
   localparam int WriteIdxW   = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
   localparam int FillW       = $clog2(WRITE_DEPTH + 1);
   localparam logic [FillW-1:0] WriteDepthFill = FillW'(WRITE_DEPTH);
   localparam logic [8:0]       WriteDepthCnt  = 9'(WRITE_DEPTH);

   // timeout register
   localparam logic [2:0] AckTimeoutReset = 3'd5;

   // input op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NACK    = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_BEGIN,
      CMD_LOAD,
      CMD_IGNORE
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_SEND,
      PH_ACK,
      PH_RECV,
      PH_MACK,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ADDR_W,
      KIND_REG,
      KIND_DATA,
      KIND_ADDR_R
   } kind_type;

   typedef struct packed {
      logic [1:0] op;
      logic       sda_in;
      logic       is_read;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   // classified word passed from front to sequencer
   typedef struct packed {
      cmd_type    cmd;
      logic       sda_in;
      logic       is_read;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
   } cmd_word_type;

   // handshake between command queue and sequencer
   typedef struct packed {
      logic valid;
      logic take;
   } cq_ctrl_type;

endpackage

// ===== rtl/imra_front.sv =====
// ----------------------------------------------------------------------------
// imra_front
// Accepts request words, classifies the op and holds them in a
// two-entry command queue for the sequencer.
// ----------------------------------------------------------------------------
module imra_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  imra_pkg::req_type      req_data,
   output logic                   cq_valid,
   input  logic                   cq_take,
   output imra_pkg::cmd_word_type cq_word
);

   imra_pkg::cmd_word_type slot_ff [2];
   imra_pkg::cmd_word_type word_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       wr_en, rd_en;

   // classify the incoming word
   always_comb begin
      word_in.sda_in     = req_data.sda_in;
      word_in.is_read    = req_data.is_read;
      word_in.dev_addr   = req_data.dev_addr;
      word_in.reg_addr   = req_data.reg_addr;
      word_in.byte_count = req_data.byte_count;
      word_in.data_byte  = req_data.data_byte;
      case (req_data.op)
         imra_pkg::OP_TICK:  word_in.cmd = imra_pkg::CMD_TICK;
         imra_pkg::OP_BEGIN: word_in.cmd = imra_pkg::CMD_BEGIN;
         imra_pkg::OP_LOAD:  word_in.cmd = imra_pkg::CMD_LOAD;
         default:            word_in.cmd = imra_pkg::CMD_IGNORE;
      endcase
   end

   assign full     = (count_ff == 2'd2);
   assign cq_valid = (count_ff != 2'd0);
   assign cq_word  = slot_ff[rd_ptr_ff];
   assign wr_en    = push && !full;
   assign rd_en    = cq_take && cq_valid;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) wr_ptr_ff <= ~wr_ptr_ff;
         if (rd_en) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

   queue_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("command queue over depth");
   queue_take_a: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !wr_en) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("command queue count lost a take");
   queue_full_a: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !rd_en) |=> (count_ff == 2'd2))
      else $error("command queue accepted while full");

endmodule

// ===== rtl/imra_seq.sv =====
// ----------------------------------------------------------------------------
// imra_seq
// Bus sequencer: one classified word per cycle while the result queue has room;
// drives the SCL/SDA levels, keeps the write buffer, builds one result word.
// ----------------------------------------------------------------------------
module imra_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_wr_data,
   input  logic                   cq_valid,
   output logic                   cq_take,
   input  imra_pkg::cmd_word_type cq_word,
   input  logic                   rq_full,
   output logic                   rq_push,
   output imra_pkg::rsp_type      rq_word
);

   localparam int IdxW = imra_pkg::WriteIdxW;

   imra_pkg::phase_type phase_ff, phase_in;
   imra_pkg::kind_type  kind_ff, kind_in;
   logic [2:0] tick_ff, tick_in;
   logic [3:0] bit_idx_ff, bit_idx_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] bytes_done_ff, bytes_done_in;
   logic [2:0] ack_wait_ff, ack_wait_in;
   logic [imra_pkg::FillW-1:0] fill_ff, fill_in;
   logic       rq_read_ff, rq_read_in;
   logic [6:0] rq_dev_ff, rq_dev_in;
   logic [7:0] rq_reg_ff, rq_reg_in;
   logic [7:0] rq_count_ff, rq_count_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in_lvl;
   logic [1:0] err_ff, err_in;
   logic [2:0] ack_timeout_ff;

   logic [7:0] wbuf_ff [imra_pkg::WRITE_DEPTH];
   logic            wbuf_we;
   logic [IdxW-1:0] wbuf_rd_idx;
   logic [7:0]      wbuf_rd;

   logic       fire;
   logic [7:0] bd_inc;
   logic [2:0] ack_inc;
   logic [2:0] ack_lim;
   logic [7:0] rx_shift;
   logic       rx_valid, done;
   logic [1:0] status;

   assign fire    = cq_valid && !rq_full;
   assign cq_take = fire;
   assign rq_push = fire;

   assign bd_inc   = bytes_done_ff + 8'd1;
   assign ack_inc  = ack_wait_ff + 3'd1;
   assign ack_lim  = (ack_timeout_ff == 3'd0) ? 3'd1 : ack_timeout_ff;
   assign rx_shift = {shift_ff[6:0], cq_word.sda_in};

   // one buffer read port: next data byte after the register or a data byte
   assign wbuf_rd_idx = (kind_ff == imra_pkg::KIND_DATA) ? bd_inc[IdxW-1:0]
                                                       : bytes_done_ff[IdxW-1:0];
   assign wbuf_rd     = wbuf_ff[wbuf_rd_idx];

   // next state and result word
   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      tick_in       = tick_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      bytes_done_in = bytes_done_ff;
      ack_wait_in   = ack_wait_ff;
      fill_in       = fill_ff;
      rq_read_in    = rq_read_ff;
      rq_dev_in     = rq_dev_ff;
      rq_reg_in     = rq_reg_ff;
      rq_count_in   = rq_count_ff;
      scl_in        = scl_ff;
      sda_in_lvl    = sda_ff;
      err_in        = err_ff;
      wbuf_we       = 1'b0;
      rx_valid      = 1'b0;
      done          = 1'b0;
      status        = imra_pkg::STATUS_OK;

      case (cq_word.cmd)
         imra_pkg::CMD_BEGIN: begin
            if (phase_ff == imra_pkg::PH_IDLE) begin
               fill_in = '0;
               if (!cq_word.is_read && ({1'b0, cq_word.byte_count} >
                                        imra_pkg::WriteDepthCnt)) begin
                  done   = 1'b1;
                  status = imra_pkg::STATUS_TOO_LONG;
               end else begin
                  rq_read_in    = cq_word.is_read;
                  rq_dev_in     = cq_word.dev_addr;
                  rq_reg_in     = cq_word.reg_addr;
                  rq_count_in   = cq_word.byte_count;
                  bytes_done_in = 8'd0;
                  ack_wait_in   = 3'd0;
                  err_in        = imra_pkg::STATUS_OK;
                  kind_in       = imra_pkg::KIND_ADDR_W;
                  phase_in      = imra_pkg::PH_START;
                  tick_in       = 3'd0;
               end
            end
         end
         imra_pkg::CMD_LOAD: begin
            if (phase_ff == imra_pkg::PH_IDLE && fill_ff < imra_pkg::WriteDepthFill) begin
               wbuf_we = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end
         imra_pkg::CMD_TICK: begin
            case (phase_ff)
               imra_pkg::PH_START: begin
                  if (tick_ff <= 3'd1) sda_in_lvl = 1'b1;
                  else if (tick_ff == 3'd2) scl_in = 1'b1;
                  else if (tick_ff == 3'd3) sda_in_lvl = 1'b0;
                  else scl_in = 1'b0;
                  if (tick_ff >= 3'd4) begin
                     // address byte, read bit only after repeated start
                     shift_in   = {rq_dev_ff, (kind_ff == imra_pkg::KIND_ADDR_R)};
                     bit_idx_in = 4'd0;
                     tick_in    = 3'd0;
                     phase_in   = imra_pkg::PH_SEND;
                  end else begin
                     tick_in = tick_ff + 3'd1;
                  end
               end
               imra_pkg::PH_SEND: begin
                  if (tick_ff <= 3'd1) scl_in = 1'b0;
                  else if (tick_ff == 3'd2) sda_in_lvl = shift_ff[7];
                  else if (tick_ff >= 3'd4) scl_in = 1'b1;
                  if (tick_ff >= 3'd4) begin
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_idx_in = bit_idx_ff + 4'd1;
                     tick_in    = 3'd0;
                     if (bit_idx_in >= 4'd8) begin
                        phase_in    = imra_pkg::PH_ACK;
                        ack_wait_in = 3'd0;
                     end
                  end else begin
                     tick_in = tick_ff + 3'd1;
                  end
               end
               imra_pkg::PH_ACK: begin
                  if (tick_ff == 3'd0) begin
                     scl_in  = 1'b0;
                     tick_in = 3'd1;
                  end else if (tick_ff == 3'd1) begin
                     sda_in_lvl = 1'b1;
                     tick_in    = 3'd2;
                  end else if (tick_ff == 3'd2) begin
                     scl_in = 1'b1;
                     // only the first address acknowledge is checked
                     if (kind_ff == imra_pkg::KIND_ADDR_W && cq_word.sda_in) begin
                        ack_wait_in = ack_inc;
                        if (ack_inc >= ack_lim || ack_inc == 3'd0) begin
                           err_in   = imra_pkg::STATUS_NACK;
                           phase_in = imra_pkg::PH_STOP;
                           tick_in  = 3'd0;
                        end
                     end else begin
                        tick_in = 3'd3;
                     end
                  end else begin
                     scl_in = 1'b0;
                     case (kind_ff)
                        imra_pkg::KIND_ADDR_W: begin
                           kind_in    = imra_pkg::KIND_REG;
                           shift_in   = rq_reg_ff;
                           bit_idx_in = 4'd0;
                           tick_in    = 3'd0;
                           phase_in   = imra_pkg::PH_SEND;
                        end
                        imra_pkg::KIND_REG: begin
                           if (rq_read_ff) begin
                              kind_in  = imra_pkg::KIND_ADDR_R;
                              phase_in = imra_pkg::PH_START;
                              tick_in  = 3'd0;
                           end else if (bytes_done_ff < rq_count_ff) begin
                              kind_in    = imra_pkg::KIND_DATA;
                              shift_in   = wbuf_rd;
                              bit_idx_in = 4'd0;
                              tick_in    = 3'd0;
                              phase_in   = imra_pkg::PH_SEND;
                           end else begin
                              phase_in = imra_pkg::PH_STOP;
                              tick_in  = 3'd0;
                           end
                        end
                        imra_pkg::KIND_DATA: begin
                           bytes_done_in = bd_inc;
                           if (bd_inc < rq_count_ff) begin
                              shift_in   = wbuf_rd;
                              bit_idx_in = 4'd0;
                              tick_in    = 3'd0;
                              phase_in   = imra_pkg::PH_SEND;
                           end else begin
                              phase_in = imra_pkg::PH_STOP;
                              tick_in  = 3'd0;
                           end
                        end
                        default: begin
                           // read address acknowledged
                           if (rq_count_ff == 8'd0) begin
                              phase_in = imra_pkg::PH_STOP;
                              tick_in  = 3'd0;
                           end else begin
                              phase_in   = imra_pkg::PH_RECV;
                              shift_in   = 8'd0;
                              bit_idx_in = 4'd0;
                              tick_in    = 3'd0;
                           end
                        end
                     endcase
                  end
               end
               imra_pkg::PH_RECV: begin
                  if (tick_ff == 3'd0) begin
                     scl_in     = 1'b0;
                     sda_in_lvl = 1'b1;
                     tick_in    = 3'd1;
                  end else if (tick_ff == 3'd1) begin
                     tick_in = 3'd2;
                  end else begin
                     scl_in     = 1'b1;
                     shift_in   = rx_shift;
                     bit_idx_in = bit_idx_ff + 4'd1;
                     tick_in    = 3'd0;
                     if (bit_idx_in >= 4'd8) begin
                        rx_valid      = 1'b1;
                        bytes_done_in = bd_inc;
                        phase_in      = imra_pkg::PH_MACK;
                     end
                  end
               end
               imra_pkg::PH_MACK: begin
                  if (tick_ff == 3'd0) begin
                     scl_in     = 1'b0;
                     sda_in_lvl = !(bytes_done_ff < rq_count_ff);
                     tick_in    = 3'd1;
                  end else if (tick_ff == 3'd1) begin
                     scl_in  = 1'b1;
                     tick_in = 3'd2;
                  end else begin
                     scl_in = 1'b0;
                     if (bytes_done_ff < rq_count_ff) begin
                        phase_in   = imra_pkg::PH_RECV;
                        shift_in   = 8'd0;
                        bit_idx_in = 4'd0;
                        tick_in    = 3'd0;
                     end else begin
                        phase_in = imra_pkg::PH_STOP;
                        tick_in  = 3'd0;
                     end
                  end
               end
               imra_pkg::PH_STOP: begin
                  if (tick_ff <= 3'd1) scl_in = 1'b0;
                  else if (tick_ff == 3'd2) sda_in_lvl = 1'b0;
                  else if (tick_ff == 3'd3) scl_in = 1'b1;
                  else sda_in_lvl = 1'b1;
                  if (tick_ff >= 3'd4) begin
                     done     = 1'b1;
                     status   = err_ff;
                     phase_in = imra_pkg::PH_IDLE;
                     tick_in  = 3'd0;
                  end else begin
                     tick_in = tick_ff + 3'd1;
                  end
               end
               imra_pkg::PH_IDLE: begin
               end
               default: begin
                  phase_in = imra_pkg::PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase

      rq_word.scl_out  = scl_in;
      rq_word.sda_out  = sda_in_lvl;
      rq_word.busy_res = (phase_in != imra_pkg::PH_IDLE);
      rq_word.rx_valid = rx_valid;
      rq_word.rx_byte  = rx_valid ? shift_in : 8'd0;
      rq_word.done_res = done;
      rq_word.status   = status;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= imra_pkg::PH_IDLE;
         kind_ff       <= imra_pkg::KIND_ADDR_W;
         tick_ff       <= 3'd0;
         bit_idx_ff    <= 4'd0;
         shift_ff      <= 8'd0;
         bytes_done_ff <= 8'd0;
         ack_wait_ff   <= 3'd0;
         fill_ff       <= '0;
         rq_read_ff    <= 1'b0;
         rq_dev_ff     <= 7'd0;
         rq_reg_ff     <= 8'd0;
         rq_count_ff   <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         err_ff        <= imra_pkg::STATUS_OK;
      end else if (fire) begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         tick_ff       <= tick_in;
         bit_idx_ff    <= bit_idx_in;
         shift_ff      <= shift_in;
         bytes_done_ff <= bytes_done_in;
         ack_wait_ff   <= ack_wait_in;
         fill_ff       <= fill_in;
         rq_read_ff    <= rq_read_in;
         rq_dev_ff     <= rq_dev_in;
         rq_reg_ff     <= rq_reg_in;
         rq_count_ff   <= rq_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_lvl;
         err_ff        <= err_in;
      end
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= imra_pkg::AckTimeoutReset;
      end else if (csr_wr_en) begin
         ack_timeout_ff <= csr_wr_data;
      end
   end

   // write buffer, no reset
   always_ff @(posedge clock) begin
      if (fire && wbuf_we) begin
         wbuf_ff[fill_ff[IdxW-1:0]] <= cq_word.data_byte;
      end
   end

   bit_idx_a: assert property (@(posedge clock) disable iff (reset)
      bit_idx_ff <= 4'd8)
      else $error("bit index ran past a byte");
   fill_busy_a: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != imra_pkg::PH_IDLE) |=> (fill_ff == $past(fill_ff)))
      else $error("write buffer filled during a transaction");
   rx_phase_a: assert property (@(posedge clock) disable iff (reset)
      (fire && rx_valid) |-> (phase_ff == imra_pkg::PH_RECV && phase_in == imra_pkg::PH_MACK))
      else $error("received byte outside receive phase");
   done_idle_a: assert property (@(posedge clock) disable iff (reset)
      (fire && done) |=> (phase_ff == imra_pkg::PH_IDLE))
      else $error("done reported with transaction still running");

endmodule

// ===== rtl/imra_rsp_q.sv =====
// ----------------------------------------------------------------------------
// imra_rsp_q
// Two-entry result queue between the sequencer and the response port.
// ----------------------------------------------------------------------------
module imra_rsp_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_push,
   output logic              wr_full,
   input  imra_pkg::rsp_type wr_word,
   output logic              empty,
   input  logic              pop,
   output imra_pkg::rsp_type rsp_data
);

   imra_pkg::rsp_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       wr_en, rd_en;

   assign wr_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign wr_en    = wr_push && !wr_full;
   assign rd_en    = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (wr_en) wr_ptr_ff <= ~wr_ptr_ff;
         if (rd_en) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_word;
      end
   end

   rsp_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue over depth");
   rsp_keep_a: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rd_en) |=> (rsp_data == $past(rsp_data)))
      else $error("waiting result word changed");
   rsp_ptr_a: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers out of step");

endmodule

// ===== rtl/i2c_master_register_access_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// I2C master stepped by tick words; writes or reads a run of bytes at one
// register of a target device.
//
//   port group     direction  handshake            payload
//   req_data       in         push / full          imra_pkg::req_type
//   rsp_data       out        empty / pop          imra_pkg::rsp_type
//   csr_wr_data    in         csr_wr_en            ack_timeout, 3 bits
//
// Every accepted word gives exactly one result word. The sequencer takes one
// word per cycle while the result queue has room, so the sustained rate is one
// word per cycle; a result passes through the command queue and the result queue
// registers on its way to rsp_data. Reset clears both queues and the sequencer
// and loads ack_timeout with 5; the write buffer is not cleared. A stalled
// result side fills the result queue, then the command queue, then raises full.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  imra_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output imra_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_data
);

   imra_pkg::cq_ctrl_type  cq_ctrl;
   imra_pkg::cmd_word_type cq_word;
   imra_pkg::rsp_type      rq_word;
   logic                   rq_push, rq_full;

   // front: accept and classify
   imra_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cq_valid (cq_ctrl.valid),
      .cq_take  (cq_ctrl.take),
      .cq_word  (cq_word)
   );

   // back: bus sequencer
   imra_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cq_valid    (cq_ctrl.valid),
      .cq_take     (cq_ctrl.take),
      .cq_word     (cq_word),
      .rq_full     (rq_full),
      .rq_push     (rq_push),
      .rq_word     (rq_word)
   );

   // result queue
   imra_rsp_q u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rq_push),
      .wr_full  (rq_full),
      .wr_word  (rq_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master register access block. Words go in
// through the push/full queue port and every word gives one result word; an
// in-bench model of the bus sequencer predicts each result, and the checker
// compares the result words field by field in order. A short table of
// directed words comes first, then bus transfers of every kind (write, read,
// empty read, absent target, over-long write, full buffer) with random
// content, over several ack timeout settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import imra_pkg::*;

   localparam int LIMIT_CYCLES    = 1_000_000;
   localparam int TAIL_CYCLES     = 4000;
   localparam int PHASES          = 6;
   localparam int XFERS_PER_PHASE = 4;
   localparam int BIG_READ_XFER   = 9;
   localparam int MAX_REPORTS     = 40;

   // op 3 has no meaning to the block
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam rsp_type RSP_IDLE     = rsp_type'{scl_out: 1'b1, sda_out: 1'b1, default: '0};
   localparam rsp_type RSP_TOO_LONG = rsp_type'{scl_out: 1'b1, sda_out: 1'b1, done_res: 1'b1,
                                                status: STATUS_TOO_LONG, default: '0};

   typedef enum int {
      XF_WRITE,
      XF_READ,
      XF_NO_TARGET,
      XF_TOO_LONG,
      XF_READ_NONE,
      XF_FULL_BUFFER
   } xfer_kind;

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type want;
   } dir_row_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   req_type    req_data = '0;
   logic       empty;
   logic       pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_wr_data = '0;

   rsp_type expected_q [$];
   int      error_count = 0;
   int      results_seen = 0;
   int      burst_left = 0;
   int      cycle_count;

   // model of the bus sequencer
   phase_type  seq_phase;
   kind_type   seq_kind;
   logic [2:0] seq_tick;
   logic [3:0] seq_bit;
   logic [7:0] seq_shift;
   logic [7:0] seq_bytes;
   logic [2:0] ack_count;
   logic [7:0] tx_buffer [WRITE_DEPTH];
   bit         tx_written [WRITE_DEPTH];
   logic [4:0] tx_fill;
   logic       req_read;
   logic [6:0] req_dev;
   logic [7:0] req_reg;
   logic [7:0] req_count;
   logic       scl_level;
   logic       sda_level;
   logic [1:0] err_status;
   logic [2:0] ack_limit;

   i2c_master_register_access_top dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic void reset_model();
      seq_phase  = PH_IDLE;
      seq_kind   = KIND_ADDR_W;
      seq_tick   = '0;
      seq_bit    = '0;
      seq_shift  = '0;
      seq_bytes  = '0;
      ack_count  = '0;
      tx_fill    = '0;
      req_read   = 1'b0;
      req_dev    = '0;
      req_reg    = '0;
      req_count  = '0;
      scl_level  = 1'b1;
      sda_level  = 1'b1;
      err_status = STATUS_OK;
      ack_limit  = AckTimeoutReset;
      for (int i = 0; i < WRITE_DEPTH; i++) begin
         tx_buffer[i]  = '0;
         tx_written[i] = 1'b0;
      end
   endfunction

   function automatic void send_byte(kind_type k, logic [7:0] value);
      seq_kind  = k;
      seq_shift = value;
      seq_bit   = '0;
      seq_tick  = '0;
      seq_phase = PH_SEND;
   endfunction

   function automatic void enter_stop();
      seq_phase = PH_STOP;
      seq_tick  = '0;
   endfunction

   function automatic logic [7:0] tx_byte(logic [7:0] idx);
      return (idx < WRITE_DEPTH) ? tx_buffer[idx[WriteIdxW-1:0]] : 8'h00;
   endfunction

   // what follows an acknowledge depends on the byte just sent
   function automatic void next_after_ack();
      case (seq_kind)
         KIND_ADDR_W: send_byte(KIND_REG, req_reg);
         KIND_REG: begin
            if (req_read) begin
               seq_kind  = KIND_ADDR_R;
               seq_phase = PH_START;
               seq_tick  = '0;
            end else if (seq_bytes < req_count) begin
               send_byte(KIND_DATA, tx_byte(seq_bytes));
            end else begin
               enter_stop();
            end
         end
         KIND_DATA: begin
            seq_bytes = seq_bytes + 8'd1;
            if (seq_bytes < req_count) send_byte(KIND_DATA, tx_byte(seq_bytes));
            else enter_stop();
         end
         default: begin
            if (req_count == 8'd0) begin
               enter_stop();
            end else begin
               seq_phase = PH_RECV;
               seq_shift = '0;
               seq_bit   = '0;
               seq_tick  = '0;
            end
         end
      endcase
   endfunction

   // one word into the sequencer, one result word out
   function automatic rsp_type master_step(req_type w);
      rsp_type    r;
      logic [2:0] t;
      logic [2:0] lim;
      r = '0;
      t = seq_tick;
      case (w.op)
         OP_BEGIN: begin
            if (seq_phase == PH_IDLE) begin
               tx_fill = '0;
               if (!w.is_read && w.byte_count > WRITE_DEPTH) begin
                  r.done_res = 1'b1;
                  r.status   = STATUS_TOO_LONG;
               end else begin
                  req_read   = w.is_read;
                  req_dev    = w.dev_addr;
                  req_reg    = w.reg_addr;
                  req_count  = w.byte_count;
                  seq_bytes  = '0;
                  ack_count  = '0;
                  err_status = STATUS_OK;
                  seq_kind   = KIND_ADDR_W;
                  seq_phase  = PH_START;
                  seq_tick   = '0;
               end
            end
         end
         OP_LOAD: begin
            if (seq_phase == PH_IDLE && tx_fill < WRITE_DEPTH) begin
               tx_buffer[tx_fill[WriteIdxW-1:0]]  = w.data_byte;
               tx_written[tx_fill[WriteIdxW-1:0]] = 1'b1;
               tx_fill = tx_fill + 5'd1;
            end
         end
         OP_TICK: begin
            case (seq_phase)
               PH_START: begin
                  if (t <= 3'd1) sda_level = 1'b1;
                  else if (t == 3'd2) scl_level = 1'b1;
                  else if (t == 3'd3) sda_level = 1'b0;
                  else scl_level = 1'b0;
                  if (t >= 3'd4) begin
                     if (seq_kind == KIND_ADDR_R) send_byte(KIND_ADDR_R, {req_dev, 1'b1});
                     else send_byte(KIND_ADDR_W, {req_dev, 1'b0});
                  end else begin
                     seq_tick = t + 3'd1;
                  end
               end
               PH_SEND: begin
                  if (t <= 3'd1) scl_level = 1'b0;
                  else if (t == 3'd2) sda_level = seq_shift[7];
                  else if (t >= 3'd4) scl_level = 1'b1;
                  if (t >= 3'd4) begin
                     seq_shift = seq_shift << 1;
                     seq_bit   = seq_bit + 4'd1;
                     seq_tick  = '0;
                     if (seq_bit >= 4'd8) begin
                        seq_phase = PH_ACK;
                        ack_count = '0;
                     end
                  end else begin
                     seq_tick = t + 3'd1;
                  end
               end
               PH_ACK: begin
                  if (t == 3'd0) begin
                     scl_level = 1'b0;
                     seq_tick  = 3'd1;
                  end else if (t == 3'd1) begin
                     sda_level = 1'b1;
                     seq_tick  = 3'd2;
                  end else if (t == 3'd2) begin
                     scl_level = 1'b1;
                     // only the first address acknowledge is looked at
                     if (seq_kind == KIND_ADDR_W && w.sda_in) begin
                        lim = (ack_limit == 3'd0) ? 3'd1 : ack_limit;
                        ack_count = ack_count + 3'd1;
                        if (ack_count >= lim || ack_count == 3'd0) begin
                           err_status = STATUS_NACK;
                           enter_stop();
                        end
                     end else begin
                        seq_tick = 3'd3;
                     end
                  end else begin
                     scl_level = 1'b0;
                     next_after_ack();
                  end
               end
               PH_RECV: begin
                  if (t == 3'd0) begin
                     scl_level = 1'b0;
                     sda_level = 1'b1;
                     seq_tick  = 3'd1;
                  end else if (t == 3'd1) begin
                     seq_tick = 3'd2;
                  end else begin
                     scl_level = 1'b1;
                     seq_shift = {seq_shift[6:0], w.sda_in};
                     seq_bit   = seq_bit + 4'd1;
                     seq_tick  = '0;
                     if (seq_bit >= 4'd8) begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = seq_shift;
                        seq_bytes  = seq_bytes + 8'd1;
                        seq_phase  = PH_MACK;
                     end
                  end
               end
               PH_MACK: begin
                  if (t == 3'd0) begin
                     scl_level = 1'b0;
                     // ack while more bytes are wanted, nack on the last
                     sda_level = (seq_bytes < req_count) ? 1'b0 : 1'b1;
                     seq_tick  = 3'd1;
                  end else if (t == 3'd1) begin
                     scl_level = 1'b1;
                     seq_tick  = 3'd2;
                  end else begin
                     scl_level = 1'b0;
                     if (seq_bytes < req_count) begin
                        seq_phase = PH_RECV;
                        seq_shift = '0;
                        seq_bit   = '0;
                        seq_tick  = '0;
                     end else begin
                        enter_stop();
                     end
                  end
               end
               PH_STOP: begin
                  if (t <= 3'd1) scl_level = 1'b0;
                  else if (t == 3'd2) sda_level = 1'b0;
                  else if (t == 3'd3) scl_level = 1'b1;
                  else sda_level = 1'b1;
                  if (t >= 3'd4) begin
                     r.done_res = 1'b1;
                     r.status   = err_status;
                     seq_phase  = PH_IDLE;
                     seq_tick   = '0;
                  end else begin
                     seq_tick = t + 3'd1;
                  end
               end
               default: seq_phase = PH_IDLE;
            endcase
         end
         default: ;
      endcase
      r.scl_out  = scl_level;
      r.sda_out  = sda_level;
      r.busy_res = (seq_phase != PH_IDLE);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type random_word();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic dir_row_t make_row(logic [1:0] op, logic sda, logic rd, logic [6:0] dev_a,
                                         logic [7:0] reg_a, logic [7:0] count_a,
                                         logic [7:0] data_a, bit typed, rsp_type want);
      dir_row_t row;
      row.w       = '{op: op, sda_in: sda, is_read: rd, dev_addr: dev_a, reg_addr: reg_a,
                      byte_count: count_a, data_byte: data_a};
      row.typed   = typed;
      row.want    = want;
      return row;
   endfunction

   // entries from the bottom of the buffer that hold a loaded byte
   function automatic int written_prefix();
      int n;
      n = 0;
      while (n < WRITE_DEPTH && tx_written[n]) n++;
      return n;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS) $display("tb: mismatch: %s", msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("word %0d %s got %0h expected %0h", results_seen, name, got,
                                want));
   endtask

   // offer one word, called and returning at a falling edge
   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (full);
      r = master_step(w);
      expected_q.push_back(typed ? typed_rsp : r);
      @(negedge clock);
   endtask

   task automatic send_tick(input logic sda);
      req_type w;
      w        = random_word();
      w.op     = OP_TICK;
      w.sda_in = sda;
      send_word(w, 1'b0, '0);
   endtask

   // wait for every outstanding result word, then let the pipe settle
   task automatic drain();
      push <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [2:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ack_limit = value;
   endtask

   // tick the bus until the transfer in flight is over, acting as the target
   task automatic run_bus(input bit no_target, input int high_left);
      req_type w;
      logic    sda;
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 31) == 0) begin
            // begin, load or spare op while busy: all ignored
            w = random_word();
            case ($urandom_range(0, 2))
               0: w.op = OP_BEGIN;
               1: w.op = OP_LOAD;
               default: w.op = OP_SPARE;
            endcase
            send_word(w, 1'b0, '0);
         end else begin
            if (seq_phase == PH_ACK && seq_kind == KIND_ADDR_W && seq_tick == 3'd2) begin
               sda = no_target || high_left > 0;
               if (high_left > 0) high_left--;
            end else begin
               sda = $urandom_range(0, 1);
            end
            send_tick(sda);
         end
      end
   endtask

   // one bus transfer: idle words, buffer loads, begin, then the bus ticks
   task automatic run_transfer(input xfer_kind kind, input bit big_read);
      req_type    w;
      int         loads;
      int         ready;
      int         high_left;
      logic [2:0] lim;
      repeat ($urandom_range(0, 3)) begin
         w    = random_word();
         w.op = $urandom_range(0, 1) ? OP_TICK : OP_SPARE;
         send_word(w, 1'b0, '0);
      end
      loads = (kind == XF_FULL_BUFFER) ? $urandom_range(WRITE_DEPTH, WRITE_DEPTH + 3)
                                       : $urandom_range(0, 5);
      repeat (loads) begin
         w    = random_word();
         w.op = OP_LOAD;
         send_word(w, 1'b0, '0);
      end
      ready = written_prefix();

      w    = random_word();
      w.op = OP_BEGIN;
      case (kind)
         XF_WRITE: begin
            w.is_read    = 1'b0;
            w.byte_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ready)
                                                       : $urandom_range(0, (ready < 3) ? ready : 3);
         end
         XF_READ: begin
            w.is_read    = 1'b1;
            w.byte_count = big_read ? 8'hFF : $urandom_range(1, 4);
         end
         XF_READ_NONE: begin
            w.is_read    = 1'b1;
            w.byte_count = 8'd0;
         end
         XF_TOO_LONG: begin
            w.is_read    = 1'b0;
            w.byte_count = $urandom_range(WRITE_DEPTH + 1, 255);
         end
         XF_FULL_BUFFER: begin
            w.is_read    = 1'b0;
            w.byte_count = ready;
         end
         default: begin
            // absent target: data is never reached, a write may ask up to WRITE_DEPTH bytes
            if (!w.is_read) w.byte_count = $urandom_range(0, WRITE_DEPTH);
         end
      endcase
      send_word(w, 1'b0, '0);

      // a present target may hold SDA high for a while before acking
      lim       = (ack_limit == 3'd0) ? 3'd1 : ack_limit;
      high_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, lim - 1) : 0;
      run_bus(kind == XF_NO_TARGET, high_left);
   endtask

   function automatic xfer_kind pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3) return XF_WRITE;
      if (r <= 6) return XF_READ;
      if (r == 7) return XF_NO_TARGET;
      if (r == 8) return XF_TOO_LONG;
      return $urandom_range(0, 1) ? XF_READ_NONE : XF_FULL_BUFFER;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      dir_row_t   rows [$];
      logic [2:0] timeout_plan [PHASES];
      xfer_kind   kind;
      int         xfer_no;
      int         n;

      timeout_plan = '{3'd7, 3'd0, 3'd1, 3'd3, 3'd6, 3'd2};
      reset_model();

      // idle words, over-long writes, loads, then a write with extreme fields
      rows.push_back(make_row(OP_TICK,  0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 1, RSP_IDLE));
      rows.push_back(make_row(OP_TICK,  1, 1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, RSP_IDLE));
      rows.push_back(make_row(OP_SPARE, 1, 1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, RSP_IDLE));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 1, RSP_IDLE));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'hFF, 1, RSP_IDLE));
      rows.push_back(make_row(OP_BEGIN, 0, 0, 7'h00, 8'h00, 8'd17, 8'h00, 1, RSP_TOO_LONG));
      rows.push_back(make_row(OP_BEGIN, 1, 0, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, RSP_TOO_LONG));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 1, RSP_IDLE));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'hFF, 1, RSP_IDLE));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'h5A, 1, RSP_IDLE));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'hC3, 1, RSP_IDLE));
      rows.push_back(make_row(OP_BEGIN, 0, 0, 7'h7F, 8'hFF, 8'd3,  8'h00, 0, '0));
      // begin, load and spare op while busy
      rows.push_back(make_row(OP_BEGIN, 0, 1, 7'h00, 8'h00, 8'd1,  8'h00, 0, '0));
      rows.push_back(make_row(OP_LOAD,  0, 0, 7'h00, 8'h00, 8'h00, 8'h77, 0, '0));
      rows.push_back(make_row(OP_SPARE, 0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, '0));
      // start condition and the first address bit
      for (int i = 0; i < 10; i++)
         rows.push_back(make_row(OP_TICK, i[0], 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
      run_bus(1'b0, 0);

      // random transfers over several timeout settings
      xfer_no = 0;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_timeout(timeout_plan[p]);
         for (int x = 0; x < XFERS_PER_PHASE; x++) begin
            if (xfer_no == BIG_READ_XFER) kind = XF_READ;
            else if (xfer_no <= XF_FULL_BUFFER) kind = xfer_kind'(xfer_no);
            else kind = pick_kind();
            run_transfer(kind, xfer_no == BIG_READ_XFER);
            xfer_no++;
         end
      end

      // wind down
      push <= 1'b0;
      for (n = 0; n < TAIL_CYCLES && expected_q.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0)
         report_error($sformatf("%0d result words never arrived", expected_q.size()));
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver: own stall pattern plus an occasional long hold-off
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int mode_left;
      int mode;
      int since_hold;
      int next_hold;
      hold_left  = 0;
      mode_left  = 0;
      mode       = 0;
      since_hold = 0;
      next_hold  = 400;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= $urandom_range(0, 1);
               default: pop <= ($urandom_range(0, 3) == 0);
            endcase
            since_hold++;
            if (since_hold >= next_hold) begin
               hold_left  = $urandom_range(64, 96);
               since_hold = 0;
               next_hold  = $urandom_range(2000, 6000);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result check, in order, field by field
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_q.size() == 0) begin
            report_error($sformatf("word %0d arrived with nothing expected", results_seen));
         end else begin
            want = expected_q.pop_front();
            check_field("scl_out",  rsp_data.scl_out,  want.scl_out);
            check_field("sda_out",  rsp_data.sda_out,  want.sda_out);
            check_field("busy_res", rsp_data.busy_res, want.busy_res);
            check_field("rx_valid", rsp_data.rx_valid, want.rx_valid);
            check_field("rx_byte",  rsp_data.rx_byte,  want.rx_byte);
            check_field("done_res", rsp_data.done_res, want.done_res);
            check_field("status",   rsp_data.status,   want.status);
         end
         results_seen++;
      end
   end

   // watchdog
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clock);
      $display("tb: FAIL");
      $finish;
   end

endmodule
